// ===== sv/sida_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_pkg
// Shared sizes, codes and types of the slot-id allocator table.
// ---------------------------------------------------------------------------
package sida_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int HANDLE_BITS = 32;

    localparam int ID_W      = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = ID_W + 1;
    localparam int WORD_BITS = 32;
    localparam int WORD_SH   = $clog2(WORD_BITS);
    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WIDX_W    = ID_W - WORD_SH;
    localparam int CNT_W     = WIDX_W + 1;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam int IN_BITS   = ID_W + HANDLE_BITS;
    localparam int OUT_BITS  = ID_W + HANDLE_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_FIND = 2'd1,
        OP_DEL  = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    // result of one word search
    typedef struct packed {
        logic               found;
        logic [WORD_SH-1:0] bit_idx;
    } search_t;

endpackage

// ===== sv/sida_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sida_word_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_word_search
// Finds the lowest free slot in one word of the valid map, honoring the
// scan start offset and the table size limit.
// ---------------------------------------------------------------------------
module sida_word_search
    import sida_pkg::*;
(
    input  logic [WORD_BITS-1:0] vword,
    input  logic [WIDX_W-1:0]    word_idx,
    input  logic                 first,
    input  logic [WORD_SH-1:0]   start_bit,
    input  logic [SIZE_W-1:0]    eff_size,
    output search_t              result
);

    logic [WIDX_W:0]        size_word;
    logic [WORD_SH-1:0]     size_bits;
    logic [WORD_BITS-1:0]   avail;
    logic                   word_full_in;
    logic                   word_part_in;

    assign size_word    = eff_size[SIZE_W-1:WORD_SH];
    assign size_bits    = eff_size[WORD_SH-1:0];
    assign word_full_in = {1'b0, word_idx} < size_word;
    assign word_part_in = {1'b0, word_idx} == size_word;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = !vword[b]
                && (!first || (WORD_SH'(b) >= start_bit))
                && (word_full_in || (word_part_in && (WORD_SH'(b) < size_bits)));
        end
    end

    // lowest set bit wins
    always_comb
    begin
        result.found   = 1'b0;
        result.bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                result.found   = 1'b1;
                result.bit_idx = WORD_SH'(b);
            end
        end
    end

endmodule

// ===== sv/slot_id_allocator_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_id_allocator_table
// Connection handle table with next-fit slot-id allocation, lookup and free.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tuser: opcode; tdata: slot_id, handle
//  m_*       out  tvalid / tready    tuser: status; tdata: result_id, result_handle
//  cfg_*     in   cfg_we             cfg_wdata: table_size
//
//  Find and delete: the transfer in moves through ST_LOOK and ST_HOLD to the result on m_*.
//  Add: ST_SCAN checks W = 1 .. ceil(size/32)+1 valid-map words, one
//  word per cycle through the shared word search; a full table goes straight to ST_HOLD.
//  The valid map is a 32x32 RAM with one valid flop per row, cleared at once
//  by reset, so no clearing pass is needed.
//  s_tready is high in idle; a pending result stalls only the block's handoff.
// ---------------------------------------------------------------------------
module slot_id_allocator_table
    import sida_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] opcode
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] slot_id, [41:10] handle
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STAT_W-1:0]     m_tuser,   // [1:0] status
    output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] result_id, [41:10] result_handle
    input  logic                  cfg_we,
    input  logic [SIZE_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]      table_size_reg;
    logic [SIZE_W-1:0]      eff_size;
    logic [SIZE_W-1:0]      used_reg, used_next;
    logic [SIZE_W-1:0]      next_free_reg, next_free_next;
    logic [NUM_WORDS-1:0]   row_valid_reg, row_valid_next;
    logic                   row_hit_reg;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;

    logic [WIDX_W-1:0]      scan_word_reg, scan_word_next;
    logic                   first_reg, first_next;
    logic [WORD_SH-1:0]     start_bit_reg, start_bit_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [STAT_W-1:0]      res_status_reg, res_status_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic [HANDLE_BITS-1:0] res_handle_reg, res_handle_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   out_load;
    logic [STAT_W-1:0]      out_status_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;

    logic                   vmap_we;
    logic [WIDX_W-1:0]      vmap_waddr, vmap_raddr;
    logic [WORD_BITS-1:0]   vmap_wdata, vmap_rdata, vword;
    logic                   hmem_we;
    logic [ID_W-1:0]        hmem_waddr, hmem_raddr;
    logic [HANDLE_BITS-1:0] hmem_rdata;

    logic [ID_W-1:0]        in_id;
    logic [HANDLE_BITS-1:0] in_handle;
    logic [ID_W-1:0]        start_pos;
    logic [WIDX_W-1:0]      last_word, scan_nxt;
    logic [WORD_BITS-1:0]   id_onehot, hit_onehot;
    logic [ID_W-1:0]        hit_pos;
    search_t                search;

    assign in_id     = s_tdata[ID_W-1:0];
    assign in_handle = s_tdata[ID_W +: HANDLE_BITS];
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (table_size_reg > SIZE_W'(MAX_SLOTS))
        begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    assign start_pos  = (next_free_reg >= eff_size) ? '0 : next_free_reg[ID_W-1:0];
    assign last_word  = WIDX_W'((eff_size - SIZE_W'(1)) >> WORD_SH);
    assign scan_nxt   = (scan_word_reg == last_word) ? '0 : scan_word_reg + WIDX_W'(1);
    assign vword      = row_hit_reg ? vmap_rdata : '0;   // unwritten rows read as free
    assign id_onehot  = WORD_BITS'(1) << id_reg[WORD_SH-1:0];
    assign hit_onehot = WORD_BITS'(1) << search.bit_idx;
    assign hit_pos    = {scan_word_reg, search.bit_idx};

    sida_word_search u_search (
        .vword     (vword),
        .word_idx  (scan_word_reg),
        .first     (first_reg),
        .start_bit (start_bit_reg),
        .eff_size  (eff_size),
        .result    (search)
    );

    sida_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_vmap (
        .clk   (clk),
        .we    (vmap_we),
        .waddr (vmap_waddr),
        .wdata (vmap_wdata),
        .raddr (vmap_raddr),
        .rdata (vmap_rdata)
    );

    sida_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_hmem (
        .clk   (clk),
        .we    (hmem_we),
        .waddr (hmem_waddr),
        .wdata (handle_reg),
        .raddr (hmem_raddr),
        .rdata (hmem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        next_free_next  = next_free_reg;
        row_valid_next  = row_valid_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        handle_next     = handle_reg;
        scan_word_next  = scan_word_reg;
        first_next      = first_reg;
        start_bit_next  = start_bit_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_handle_next = res_handle_reg;
        vmap_we         = 1'b0;
        vmap_waddr      = scan_word_reg;
        vmap_wdata      = vword;
        vmap_raddr      = scan_nxt;
        hmem_we         = 1'b0;
        hmem_waddr      = hit_pos;
        hmem_raddr      = in_id;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tuser == OP_ADD)
                begin
                    vmap_raddr = start_pos[ID_W-1:WORD_SH];
                end
                else
                begin
                    vmap_raddr = in_id[ID_W-1:WORD_SH];
                end
                if (s_tvalid)
                begin
                    op_next         = s_tuser;
                    id_next         = in_id;
                    handle_next     = in_handle;
                    res_id_next     = in_id;
                    res_handle_next = '0;
                    res_status_next = STAT_OK;
                    case (s_tuser)
                        OP_ADD:
                        begin
                            if (used_reg >= eff_size)
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_HOLD;
                            end
                            else
                            begin
                                scan_word_next = start_pos[ID_W-1:WORD_SH];
                                start_bit_next = start_pos[WORD_SH-1:0];
                                first_next     = 1'b1;
                                // every word in range once, plus a revisit of the first
                                cnt_next       = {1'b0, last_word} + CNT_W'(2);
                                state_next     = ST_SCAN;
                            end
                        end
                        OP_FIND, OP_DEL:
                        begin
                            state_next = ST_LOOK;
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                vmap_waddr = id_reg[ID_W-1:WORD_SH];
                vmap_wdata = vword & ~id_onehot;
                if ({1'b0, id_reg} >= eff_size)
                begin
                    res_status_next = STAT_RANGE;
                end
                else if (!vword[id_reg[WORD_SH-1:0]])
                begin
                    res_status_next = STAT_EMPTY;
                end
                else if (op_reg == OP_FIND)
                begin
                    res_handle_next = hmem_rdata;
                end
                else
                begin
                    vmap_we = 1'b1;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - SIZE_W'(1);
                    end
                end
                state_next = ST_HOLD;
            end
            ST_SCAN:
            begin
                vmap_wdata = vword | hit_onehot;
                if (search.found)
                begin
                    vmap_we                       = 1'b1;
                    hmem_we                       = 1'b1;
                    row_valid_next[scan_word_reg] = 1'b1;
                    next_free_next                = {1'b0, hit_pos} + SIZE_W'(1);
                    used_next                     = used_reg + SIZE_W'(1);
                    res_id_next                   = hit_pos;
                    state_next                    = ST_HOLD;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    // no free slot below the size, even with room in the count
                    res_status_next = STAT_FULL;
                    state_next      = ST_HOLD;
                end
                else
                begin
                    cnt_next       = cnt_reg - CNT_W'(1);
                    first_next     = 1'b0;
                    scan_word_next = scan_nxt;
                end
            end
            ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            table_size_reg <= SIZE_W'(MAX_SLOTS);
            used_reg       <= '0;
            next_free_reg  <= '0;
            row_valid_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            next_free_reg <= next_free_next;
            row_valid_reg <= row_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_hit_reg    <= row_valid_reg[vmap_raddr];
        op_reg         <= op_next;
        id_reg         <= id_next;
        handle_reg     <= handle_next;
        scan_word_reg  <= scan_word_next;
        first_reg      <= first_next;
        start_bit_reg  <= start_bit_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_handle_reg <= res_handle_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_handle_reg <= res_handle_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_handle_reg, out_id_reg};

    // used count can never pass the number of slots
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SIZE_W'(MAX_SLOTS))
        else $error("used count above slot count");

    // a new result only ever comes from the handoff state
    a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result presented without handoff");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted item dropped");

    // the scan never runs with an exhausted word budget
    a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg != '0)
        else $error("scan count exhausted");

    // an allocated slot always lies below the table size
    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && search.found |-> {1'b0, hit_pos} < eff_size)
        else $error("slot allocated beyond table size");

endmodule
